// ===== rtl/core/ccid_pkg.sv =====
// Shared types and constants for the content-coding inner detector.
// Holds the keyword tables, separator codes and the per-token match state.
// No dependencies.
`default_nettype none

package ccid_pkg;

   // Keyword lengths and the saturating position limit
   localparam int unsigned KW_CHUNKED_LEN  = 11;
   localparam int unsigned KW_IDENTITY_LEN = 8;
   localparam int unsigned POS_W           = 4;
   localparam logic [POS_W-1:0] POS_MAX    = 4'd15;
   localparam logic [POS_W-1:0] POS_CHUNKED_END  = 4'(KW_CHUNKED_LEN);
   localparam logic [POS_W-1:0] POS_IDENTITY_END = 4'(KW_IDENTITY_LEN);

   // Byte codes
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Keyword tables, stored already lower case
   localparam logic [7:0] KW_CHUNKED [KW_CHUNKED_LEN] = '{
      8'h61, 8'h77, 8'h73, 8'h2D, 8'h63, 8'h68, 8'h75, 8'h6E, 8'h6B, 8'h65, 8'h64
   };
   localparam logic [7:0] KW_IDENTITY [KW_IDENTITY_LEN] = '{
      8'h69, 8'h64, 8'h65, 8'h6E, 8'h74, 8'h69, 8'h74, 8'h79
   };

   // Match state of the token in progress
   typedef struct packed {
      logic             token_started;
      logic             space_pending;
      logic [POS_W-1:0] match_position;
      logic             chunked_alive;
      logic             identity_alive;
   } token_state_type;

   localparam token_state_type TOKEN_CLEAR = '{
      token_started:  1'b0,
      space_pending:  1'b0,
      match_position: '0,
      chunked_alive:  1'b1,
      identity_alive: 1'b1
   };

endpackage : ccid_pkg

`default_nettype wire

// ===== rtl/core/ccid_if.sv =====
// Valid/ready channel interfaces for the content-coding inner detector:
// one for header bytes in, one for the result word out.
// No dependencies.
`default_nettype none

interface ccid_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       byte_valid;
   logic       last_byte;

   modport source (output valid, value_byte, byte_valid, last_byte, input ready);
   modport sink   (input valid, value_byte, byte_valid, last_byte, output ready);
endinterface : ccid_req_if

interface ccid_rsp_if;
   logic valid;
   logic ready;
   logic has_inner_coding;

   modport source (output valid, has_inner_coding, input ready);
   modport sink   (input valid, has_inner_coding, output ready);
endinterface : ccid_rsp_if

`default_nettype wire

// ===== rtl/core/ccid_matcher.sv =====
// Per-byte token matcher: folds case, splits on commas, trims whitespace and
// tracks the two keywords. Pure combinational; depends on ccid_pkg.
`default_nettype none

module ccid_matcher
   import ccid_pkg::*;
(
   input  wire token_state_type cur_state,
   input  wire [7:0]            value_byte,
   input  wire                  byte_valid,
   input  wire                  last_byte,
   output token_state_type      next_state,
   output logic                 inner_hit
);

   logic            is_comma;
   logic            is_space;
   logic            is_upper;
   logic [7:0]      folded;
   logic            chunked_eq;
   logic            identity_eq;
   logic            comma_inner;
   logic            last_inner;
   token_state_type after_byte;

   // Classify the incoming byte
   assign is_comma = (value_byte == CHAR_COMMA);
   assign is_space = (value_byte == CHAR_SPACE) || (value_byte == CHAR_TAB);
   assign is_upper = (value_byte >= CHAR_UPPER_A) && (value_byte <= CHAR_UPPER_Z);
   assign folded   = is_upper ? (value_byte + CASE_OFFSET) : value_byte;

   // Keyword character compare at the current position
   assign chunked_eq  = (cur_state.match_position < POS_CHUNKED_END) &&
                        (KW_CHUNKED[cur_state.match_position] == folded);
   assign identity_eq = (cur_state.match_position < POS_IDENTITY_END) &&
                        (KW_IDENTITY[cur_state.match_position[2:0]] == folded);

   // A finished token counts as inner unless it exactly matched a keyword
   function automatic logic token_is_inner(token_state_type s);
      logic is_chunked;
      logic is_identity;
      is_chunked  = s.chunked_alive && (s.match_position == POS_CHUNKED_END);
      is_identity = s.identity_alive && (s.match_position == POS_IDENTITY_END);
      return s.token_started && !is_chunked && !is_identity;
   endfunction

   // State after taking this byte
   always_comb begin
      after_byte  = cur_state;
      comma_inner = 1'b0;
      if (byte_valid) begin
         if (is_comma) begin
            comma_inner = token_is_inner(cur_state);
            after_byte  = TOKEN_CLEAR;
         end else if (is_space) begin
            after_byte.space_pending = cur_state.space_pending | cur_state.token_started;
         end else begin
            // inner whitespace kills both keywords
            after_byte.token_started  = 1'b1;
            after_byte.space_pending  = 1'b0;
            after_byte.chunked_alive  = cur_state.chunked_alive &&
                                        !cur_state.space_pending && chunked_eq;
            after_byte.identity_alive = cur_state.identity_alive &&
                                        !cur_state.space_pending && identity_eq;
            if (cur_state.match_position < POS_MAX) begin
               after_byte.match_position = cur_state.match_position + 4'd1;
            end
         end
      end
   end

   // End of value closes any open token
   assign last_inner = last_byte && token_is_inner(after_byte);
   assign inner_hit  = comma_inner || last_inner;
   assign next_state = last_byte ? TOKEN_CLEAR : after_byte;

endmodule : ccid_matcher

`default_nettype wire

// ===== rtl/core/content_coding_inner_detect_core.sv =====
// Content-coding inner detector, top level. Depends on ccid_pkg, ccid_if
// and ccid_matcher.
`default_nettype none

// Takes one header-value byte per word on req_bus and gives one result word
// on rsp_bus for each word marked last_byte, in the cycle after that word is
// accepted. The block takes a word in every cycle that no held result stalls:
// the per-byte matcher update is a single short stage from the token state
// registers, and the result waits in an output register. req_bus.ready drops
// only while a result is held and rsp_bus.ready is low. A lone word with
// byte_valid low and last_byte high reports 0; words with byte_valid low and
// last_byte low are absorbed. A last word resets the token and flag state.
module content_coding_inner_detect_core
   import ccid_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   ccid_req_if.sink        req_bus,
   ccid_rsp_if.source      rsp_bus
);

   token_state_type token_ff;
   token_state_type token_in;
   logic            inner_found_ff;
   logic            inner_found_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            rsp_flag_ff;
   logic            rsp_flag_in;
   token_state_type match_next;
   logic            inner_hit;
   logic            req_take;
   logic            rsp_take;

   // Handshakes
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   ccid_matcher u_matcher (
      .cur_state  (token_ff),
      .value_byte (req_bus.value_byte),
      .byte_valid (req_bus.byte_valid),
      .last_byte  (req_bus.last_byte),
      .next_state (match_next),
      .inner_hit  (inner_hit)
   );

   // Next state of token, sticky flag and output register
   always_comb begin
      token_in       = token_ff;
      inner_found_in = inner_found_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_flag_in    = rsp_flag_ff;
      if (req_take) begin
         token_in = match_next;
         if (req_bus.last_byte) begin
            inner_found_in = 1'b0;
            rsp_valid_in   = 1'b1;
            rsp_flag_in    = inner_found_ff | inner_hit;
         end else begin
            inner_found_in = inner_found_ff | inner_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff       <= TOKEN_CLEAR;
         inner_found_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         token_ff       <= token_in;
         inner_found_ff <= inner_found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.has_inner_coding = rsp_flag_ff;

endmodule : content_coding_inner_detect_core

`default_nettype wire

// ===== rtl/core/ccid_checker.sv =====
// Port-level checks for the content-coding inner detector, bound to
// content_coding_inner_detect_core. Depends on ccid_if only through the bind.
`default_nettype none

module ccid_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire req_last_byte,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_has_inner_coding
);

   // A last word always yields a result word in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_byte) |=> rsp_valid)
      else $error("no result after last word");

   // A new result appears only after a last word was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_byte))
      else $error("result without last word");

   // Input side stays open unless a result is stuck
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled without output backpressure");

   // Held result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_has_inner_coding)))
      else $error("stalled result changed");

endmodule : ccid_checker

bind content_coding_inner_detect_core ccid_checker u_ccid_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .req_last_byte        (req_bus.last_byte),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_has_inner_coding (rsp_bus.has_inner_coding)
);

`default_nettype wire

// ===== tb/sv/content_coding_inner_detect_core_test.sv =====
// Self-checking testbench for content_coding_inner_detect_core.
// Streams header-value words through the req/rsp valid/ready interfaces and
// checks each result word. Depends on ccid_pkg, ccid_if and the core RTL.
`timescale 1ns / 1ps

module content_coding_inner_detect_core_test;
   import ccid_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_WORDS = 500;
   localparam int IDLE_LIMIT   = 500;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;

   // One header word as queued for the driver
   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       last_byte;
      logic       wait_drain;
   } hdr_word_type;

   logic clock;
   logic reset;

   ccid_req_if req_bus ();
   ccid_rsp_if rsp_bus ();

   content_coding_inner_detect_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   hdr_word_type header_word_q[$];
   logic         coding_flag_q[$];
   logic [7:0]   text_q[$];

   // Scanner copy used to predict the flag
   token_state_type scan_tok = TOKEN_CLEAR;
   logic            scan_inner = 1'b0;

   hdr_word_type next_word;
   logic drain_next = 1'b0;
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int rsp_calm = 0;
   int idle_cycles = 0;
   int words_total = 0;
   int words_taken = 0;
   int stim_words = 0;
   int headers_sent = 0;
   int results_seen = 0;
   int flagged_seen = 0;
   int drain_holds = 0;
   int mismatches = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Gap length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic logic [7:0] pick_ws();
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   // ---------------- prediction ----------------

   task automatic close_token();
      logic is_chunked;
      logic is_identity;
      is_chunked  = scan_tok.chunked_alive && scan_tok.match_position == POS_CHUNKED_END;
      is_identity = scan_tok.identity_alive && scan_tok.match_position == POS_IDENTITY_END;
      if (scan_tok.token_started && !is_chunked && !is_identity)
         scan_inner = 1'b1;
      scan_tok = TOKEN_CLEAR;
   endtask

   task automatic scan_word(input logic [7:0] b, input logic bv, input logic lst);
      logic [7:0] folded;
      if (bv) begin
         if (b == CHAR_COMMA) begin
            close_token();
         end else if (b == CHAR_SPACE || b == CHAR_TAB) begin
            if (scan_tok.token_started) scan_tok.space_pending = 1'b1;
         end else begin
            folded = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
            // whitespace followed by content spoils both keywords
            if (scan_tok.space_pending) begin
               scan_tok.chunked_alive  = 1'b0;
               scan_tok.identity_alive = 1'b0;
               scan_tok.space_pending  = 1'b0;
            end
            scan_tok.token_started = 1'b1;
            if (scan_tok.match_position >= POS_CHUNKED_END)
               scan_tok.chunked_alive = 1'b0;
            else if (KW_CHUNKED[scan_tok.match_position] != folded)
               scan_tok.chunked_alive = 1'b0;
            if (scan_tok.match_position >= POS_IDENTITY_END)
               scan_tok.identity_alive = 1'b0;
            else if (KW_IDENTITY[scan_tok.match_position[2:0]] != folded)
               scan_tok.identity_alive = 1'b0;
            if (scan_tok.match_position < POS_MAX)
               scan_tok.match_position = scan_tok.match_position + 1'b1;
         end
      end
      if (lst) begin
         close_token();
         coding_flag_q.push_back(scan_inner);
         scan_tok   = TOKEN_CLEAR;
         scan_inner = 1'b0;
      end
   endtask

   // ---------------- stimulus building ----------------

   task automatic push_word(input logic [7:0] b, input logic bv, input logic lst);
      hdr_word_type w;
      w.value_byte = b;
      w.byte_valid = bv;
      w.last_byte  = lst;
      w.wait_drain = drain_next;
      drain_next   = 1'b0;
      header_word_q.push_back(w);
      words_total++;
      if (bv || lst) stim_words++;
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // Keyword with random case, sometimes broken; or random bytes; or nothing
   task automatic add_token();
      logic [7:0] tok_q[$];
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         if (r < 40) begin
            for (int i = 0; i < KW_CHUNKED_LEN; i++) tok_q.push_back(KW_CHUNKED[i]);
         end else begin
            for (int i = 0; i < KW_IDENTITY_LEN; i++) tok_q.push_back(KW_IDENTITY[i]);
         end
         foreach (tok_q[i])
            if (tok_q[i] >= LOWER_A && tok_q[i] <= LOWER_Z && $urandom_range(0, 1) != 0)
               tok_q[i] = tok_q[i] ^ CASE_OFFSET;
         n = tok_q.size();
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: tok_q[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
               1: tok_q.delete(n - 1);
               2: tok_q.push_back(8'($urandom_range(33, 126)));
               default: tok_q.insert($urandom_range(1, n - 1), pick_ws());
            endcase
         end
      end else if (r < 92) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
         repeat (n) tok_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (tok_q[i]) text_q.push_back(tok_q[i]);
   endtask

   task automatic build_random_header();
      int ntok;
      text_q.delete();
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3))
            text_q.push_back(($urandom_range(0, 1) != 0) ? CHAR_COMMA : pick_ws());
      ntok = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 3);
      for (int t = 0; t < ntok; t++) begin
         repeat ($urandom_range(0, 1)) text_q.push_back(pick_ws());
         add_token();
         repeat ($urandom_range(0, 2)) text_q.push_back(pick_ws());
         if (t < ntok - 1) text_q.push_back(CHAR_COMMA);
      end
      if ($urandom_range(0, 4) == 0) begin
         text_q.push_back(CHAR_COMMA);
         repeat ($urandom_range(0, 2)) text_q.push_back(pick_ws());
      end
   endtask

   // Send text_q as one header: last on the final byte, or a bare terminator
   task automatic emit_header(input logic bare_end);
      int n;
      n = text_q.size();
      if (n == 0) bare_end = 1'b1;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         push_word(text_q[i], 1'b1, !bare_end && i == n - 1);
      end
      if (bare_end) push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      text_q.delete();
      headers_sent++;
   endtask

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fired) begin
         // word still waiting for ready
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap--;
      end else if (header_word_q.size() != 0 &&
                   !(header_word_q[0].wait_drain && coding_flag_q.size() != 0)) begin
         next_word = header_word_q.pop_front();
         if (next_word.wait_drain) drain_holds++;
         req_bus.value_byte <= next_word.value_byte;
         req_bus.byte_valid <= next_word.byte_valid;
         req_bus.last_byte  <= next_word.last_byte;
         req_bus.valid      <= 1'b1;
         send_gap = pick_gap(send_calm);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // ---------------- result backpressure ----------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = pick_gap(rsp_calm);
      end
   end

   // ---------------- monitor, checker and watchdog ----------------
   always @(posedge clock) begin
      req_fired = !reset && req_bus.valid && req_bus.ready;
      rsp_fired = !reset && rsp_bus.valid && rsp_bus.ready;
      if (rsp_fired) begin
         results_seen++;
         if (rsp_bus.has_inner_coding) flagged_seen++;
         if (coding_flag_q.size() == 0) begin
            report_mismatch($sformatf("result word %0d with no header pending",
                                      results_seen));
         end else if (rsp_bus.has_inner_coding !== coding_flag_q[0]) begin
            report_mismatch($sformatf("has_inner_coding got %b want %b on result %0d",
                                      rsp_bus.has_inner_coding, coding_flag_q[0],
                                      results_seen));
            void'(coding_flag_q.pop_front());
         end else begin
            void'(coding_flag_q.pop_front());
         end
      end
      if (req_fired) begin
         words_taken++;
         scan_word(req_bus.value_byte, req_bus.byte_valid, req_bus.last_byte);
      end
      if (reset || req_fired || rsp_fired) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------- stimulus and end of run ----------------
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.value_byte = 8'h00;
      req_bus.byte_valid = 1'b0;
      req_bus.last_byte  = 1'b0;
      rsp_bus.ready      = 1'b0;

      // Absent header: one bare terminator
      emit_header(1'b1);
      // Keyword in mixed case with trailing space trimmed
      add_str("IdEnTiTy ");
      emit_header(1'b0);
      // Field extremes as single-byte tokens
      push_word(8'hFF, 1'b1, 1'b1);
      push_word(8'h00, 1'b1, 1'b1);
      // Only separators and whitespace
      add_str(", \t");
      emit_header(1'b0);
      // Sender waits for a full drain; ignored word, then space inside a token
      drain_next = 1'b1;
      push_word(8'hA5, 1'b0, 1'b0);
      add_str("a b");
      emit_header(1'b0);
      // Ignored word followed by a bare terminator
      push_word(8'h5A, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b1);

      // Random headers, mostly keyword lists
      while (stim_words < RANDOM_WORDS) begin
         drain_next = ($urandom_range(0, 19) == 0);
         build_random_header();
         emit_header($urandom_range(0, 3) == 0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (header_word_q.size() != 0 || words_taken != words_total) @(posedge clock);
      while (coding_flag_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d header values as %0d words; %0d results checked, %0d flagged.",
               headers_sent, words_taken, results_seen, flagged_seen);
      $display("Sender held for a full drain %0d times.", drain_holds);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule : content_coding_inner_detect_core_test
